// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define BHPQ_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// The same with a fixed message.
`define BHPQ_ASSERT(lbl, clk, rst_n, prop) \
    `BHPQ_ASSERT_MSG(lbl, clk, rst_n, prop, "heap queue check failed")

`endif

// ===== sv/bhpq_pkg.sv =====
`timescale 1ns / 1ps

package bhpq_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Operation codes carried in the action field.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Heap order register values.
    localparam logic ORDER_MAX = 1'b0;
    localparam logic ORDER_MIN = 1'b1;

endpackage

// ===== sv/bhpq_if.sv =====
`timescale 1ns / 1ps

interface bhpq_cmd_if #(
    parameter int KEY_WIDTH = 32
);
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [KEY_WIDTH-1:0] key_in;

    modport source (output valid, output action, output key_in, input ready);
    modport sink   (input valid, input action, input key_in, output ready);
endinterface

interface bhpq_rsp_if #(
    parameter int KEY_WIDTH = 32,
    parameter int CNT_WIDTH = 9
);
    logic                 valid;
    logic                 ready;
    bhpq_pkg::t_status    status;
    logic [KEY_WIDTH-1:0] popped_key;
    logic [CNT_WIDTH-1:0] entry_count;
    logic [KEY_WIDTH-1:0] top_key;
    logic                 top_valid;

    modport source (output valid, output status, output popped_key, output entry_count,
                    output top_key, output top_valid, input ready);
    modport sink   (input valid, input status, input popped_key, input entry_count,
                    input top_key, input top_valid, output ready);
endinterface

interface bhpq_cfg_if;
    logic valid;
    logic ready;
    logic heap_order;

    modport source (output valid, output heap_order, input ready);
    modport sink   (input valid, input heap_order, output ready);
endinterface

// ===== sv/binary_heap_priority_queue.sv =====
// Binary heap priority queue holding up to DEPTH keys in one RAM (one write and one
// registered read port), root at entry 0 and children of entry i at 2i+1 and 2i+2.
// One command item is taken at a time; the result item is held on the response
// channel until taken, and only then is the next command accepted. A push climbs
// and a pop descends the heap level by level; the single RAM read port fetches one
// parent, or the two children one after the other, for each level. Errors (pop on
// empty, push on full) go straight to the response and change nothing. The heap
// order register may be written whenever no command is in progress; the RAM needs
// no clearing, as only entries that hold keys are ever read.
`timescale 1ns / 1ps

module binary_heap_priority_queue #(
    parameter int DEPTH     = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bhpq_cmd_if.sink    i_cmd,
    bhpq_rsp_if.source  o_rsp,
    bhpq_cfg_if.sink    i_cfg
);

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam int CW = AW + 2;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_UP_RD   = 10'b0000000010,
        S_UP_CMP  = 10'b0000000100,
        S_DN_LAST = 10'b0000001000,
        S_DN_LOAD = 10'b0000010000,
        S_DN_RDL  = 10'b0000100000,
        S_DN_RDR  = 10'b0001000000,
        S_DN_CMP  = 10'b0010000000,
        S_WR_FIN  = 10'b0100000000,
        S_RESP    = 10'b1000000000
    } t_state;

    t_state               r_state, n_state;
    logic [NW-1:0]        r_count, n_count;
    logic                 r_order;
    logic [KEY_WIDTH-1:0] r_root, n_root;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [AW-1:0]        r_pos, n_pos;
    logic [KEY_WIDTH-1:0] r_lval, n_lval;
    bhpq_pkg::t_status    r_status, n_status;
    logic [KEY_WIDTH-1:0] r_popped, n_popped;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [KEY_WIDTH-1:0] rd_data;

    logic [AW-1:0]        parent;
    logic [CW-1:0]        lc_idx;
    logic [CW-1:0]        rc_idx;
    logic [CW-1:0]        cnt_ext;
    logic                 lc_ok;
    logic                 rc_ok;
    logic                 take_left;
    logic                 take_right;
    logic [KEY_WIDTH-1:0] best_left;

    // True when key a sits above key b in the selected order.
    function automatic logic beats(input logic order, input logic [KEY_WIDTH-1:0] a,
                                   input logic [KEY_WIDTH-1:0] b);
        return (order == bhpq_pkg::ORDER_MIN) ? (a < b) : (a > b);
    endfunction

    bhpq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign parent  = (r_pos - AW'(1)) >> 1;
    assign lc_idx  = {1'b0, r_pos, 1'b1};
    assign rc_idx  = {1'b0, r_pos, 1'b0} + CW'(2);
    assign cnt_ext = CW'(r_count);
    assign lc_ok   = lc_idx < cnt_ext;
    assign rc_ok   = rc_idx < cnt_ext;

    // Sift-down choice: a child wins whenever the current best does not beat it,
    // so on equal keys the right child is taken.
    assign take_left  = !beats(r_order, r_key, r_lval);
    assign best_left  = take_left ? r_lval : r_key;
    assign take_right = rc_ok && !beats(r_order, best_left, rd_data);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_key    = r_key;
        n_pos    = r_pos;
        n_lval   = r_lval;
        n_status = r_status;
        n_popped = r_popped;
        wr_en    = 1'b0;
        wr_addr  = r_pos;
        wr_data  = r_key;
        rd_en    = 1'b0;
        rd_addr  = parent;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_status = bhpq_pkg::ST_OK;
                    n_popped = '0;
                    if (i_cmd.action == bhpq_pkg::ACT_PUSH) begin
                        if (r_count >= NW'(DEPTH)) begin
                            n_status = bhpq_pkg::ST_FULL;
                            n_state  = S_RESP;
                        end else begin
                            n_key   = i_cmd.key_in;
                            n_pos   = r_count[AW-1:0];
                            n_count = r_count + NW'(1);
                            n_state = (r_count == '0) ? S_WR_FIN : S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = bhpq_pkg::ST_EMPTY;
                            n_state  = S_RESP;
                        end else begin
                            n_popped = r_root;
                            n_count  = r_count - NW'(1);
                            n_state  = (r_count == NW'(1)) ? S_RESP : S_DN_LAST;
                        end
                    end
                end
            end
            S_UP_RD: begin
                rd_en   = 1'b1;
                rd_addr = parent;
                n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                wr_en = 1'b1;
                if (beats(r_order, r_key, rd_data)) begin
                    wr_data = rd_data;
                    n_pos   = parent;
                    n_state = (parent == '0) ? S_WR_FIN : S_UP_RD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_DN_LAST: begin
                // The count has already dropped, so it indexes the last entry.
                rd_en   = 1'b1;
                rd_addr = r_count[AW-1:0];
                n_state = S_DN_LOAD;
            end
            S_DN_LOAD: begin
                n_key   = rd_data;
                n_pos   = '0;
                n_state = S_DN_RDL;
            end
            S_DN_RDL: begin
                if (lc_ok) begin
                    rd_en   = 1'b1;
                    rd_addr = lc_idx[AW-1:0];
                    n_state = S_DN_RDR;
                end else begin
                    n_state = S_WR_FIN;
                end
            end
            S_DN_RDR: begin
                n_lval  = rd_data;
                rd_en   = rc_ok;
                rd_addr = rc_idx[AW-1:0];
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                wr_en = 1'b1;
                if (take_right) begin
                    wr_data = rd_data;
                    n_pos   = rc_idx[AW-1:0];
                    n_state = S_DN_RDL;
                end else if (take_left) begin
                    wr_data = r_lval;
                    n_pos   = lc_idx[AW-1:0];
                    n_state = S_DN_RDL;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_WR_FIN: begin
                wr_en   = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The root is shadowed in a register so that the top key and a popped key
    // never need a RAM read.
    assign n_root = (wr_en && wr_addr == '0) ? wr_data : r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_order <= bhpq_pkg::ORDER_MAX;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg.valid) begin
                r_order <= i_cfg.heap_order;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_root   <= n_root;
        r_key    <= n_key;
        r_pos    <= n_pos;
        r_lval   <= n_lval;
        r_status <= n_status;
        r_popped <= n_popped;
    end

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_rsp.valid       = (r_state == S_RESP);
    assign o_rsp.status      = r_status;
    assign o_rsp.popped_key  = r_popped;
    assign o_rsp.entry_count = r_count;
    assign o_rsp.top_valid   = (r_count != '0);
    assign o_rsp.top_key     = (r_count != '0) ? r_root : '0;

endmodule

// ===== sv/bhpq_ram.sv =====
`timescale 1ns / 1ps

module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/bhpq_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bhpq_checker #(
    parameter int DEPTH     = 256,
    parameter int KEY_WIDTH = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cmd_valid,
    input logic                         i_cmd_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input bhpq_pkg::t_status            i_rsp_status,
    input logic [KEY_WIDTH-1:0]         i_rsp_popped_key,
    input logic [$clog2(DEPTH+1)-1:0]   i_rsp_entry_count,
    input logic                         i_rsp_top_valid
);

    localparam int NW = $clog2(DEPTH + 1);

    // One command at a time: once an item is taken the block is busy until it answers.
    `BHPQ_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_cmd_valid && i_cmd_ready) |=> !i_cmd_ready)

    // A result that waits keeps its status, popped key and entry count.
    `BHPQ_ASSERT(a_rsp_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_popped_key) && $stable(i_rsp_entry_count)))

    // The top is valid exactly when the heap holds a key.
    `BHPQ_ASSERT_MSG(a_top_valid, i_clk, i_rst_n, i_rsp_valid |-> (i_rsp_top_valid == (i_rsp_entry_count != '0)), "top_valid disagrees with entry_count")

    // A rejected push is only reported when the heap is full.
    `BHPQ_ASSERT(a_full_count, i_clk, i_rst_n, (i_rsp_valid && i_rsp_status == bhpq_pkg::ST_FULL) |-> (i_rsp_entry_count == NW'(DEPTH)))

    // A failed pop leaves an empty heap and returns no key.
    `BHPQ_ASSERT(a_empty_pop, i_clk, i_rst_n, (i_rsp_valid && i_rsp_status == bhpq_pkg::ST_EMPTY) |-> (i_rsp_entry_count == '0 && i_rsp_popped_key == '0))

endmodule

bind binary_heap_priority_queue bhpq_checker #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
) u_bhpq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cmd_valid       (i_cmd.valid),
    .i_cmd_ready       (i_cmd.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_popped_key  (o_rsp.popped_key),
    .i_rsp_entry_count (o_rsp.entry_count),
    .i_rsp_top_valid   (o_rsp.top_valid)
);
